// ===== hw/rtl/pmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsd_pkg: shared types and constants of the Park-Miller draw unit
// Word type, modulus, reset values, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsd_pkg;

    typedef logic [30:0] pm_word_t;

    localparam pm_word_t PM_MOD         = 31'h7FFF_FFFF;
    localparam pm_word_t MULT_RESET     = 31'd16807;
    localparam pm_word_t SENTINEL_RESET = 31'd1;

    typedef enum logic [1:0] {
        CMD_SEED_WIDE   = 2'd0,
        CMD_SEED_NARROW = 2'd1,
        CMD_DRAW32      = 2'd2,
        CMD_DRAW64      = 2'd3
    } cmd_t;

    localparam logic CFG_IDX_MULT     = 1'b0;
    localparam logic CFG_IDX_SENTINEL = 1'b1;

    typedef struct packed {
        pm_word_t multiplier;
        pm_word_t zero_sentinel;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/park_miller_seeded_draw_unit.sv =====
// ----------------------------------------------------------------------------
// park_miller_seeded_draw_unit: Park-Miller generator with seeding
// From accept to m_tvalid: a seed or refused draw goes straight to ST_EMIT, a draw
// runs ST_MUL and ST_FOLD in the one shared step unit, and a 64-bit draw goes round
// them again for its low word. One transaction at a time: s_tready stays low until
// ST_EMIT moves the result to the output registers, longer while m_tready is low.
// Reset: multiplier 16807, sentinel 1, state 1, unseeded.
// ----------------------------------------------------------------------------
`default_nettype none

module park_miller_seeded_draw_unit
    import pmsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] seed_value
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] draw
    output logic             m_tuser    // [0] status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FOLD = 4'b0100,
        ST_EMIT = 4'b1000
    } fsm_t;

    cfg_t        cfg;
    pm_word_t    step_result;
    logic        mul_en;

    fsm_t        state_reg,      state_next;
    cmd_t        cmd_reg,        cmd_next;
    logic        second_reg,     second_next;
    pm_word_t    gen_state_reg,  gen_state_next;
    logic        seeded_reg,     seeded_next;
    pm_word_t    first_reg,      first_next;
    logic [63:0] res_draw_reg,   res_draw_next;
    logic        res_status_reg, res_status_next;
    logic        m_tvalid_reg,   m_tvalid_next;
    logic [63:0] m_tdata_reg,    m_tdata_next;
    logic        m_tuser_reg,    m_tuser_next;

    logic        accept;
    logic        out_free;
    cmd_t        cmd_in;
    logic [31:0] raw_seed;
    pm_word_t    seed_load;

    pmsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmsd_step_unit u_step (
        .clk       (clk),
        .mul_en    (mul_en),
        .operand_a (gen_state_reg),
        .operand_b (cfg.multiplier),
        .result    (step_result)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cmd_in   = cmd_t'(s_tuser);
    assign mul_en   = (state_reg == ST_MUL);

    // fold the wide seed, then replace zero or the modulus with the sentinel
    assign raw_seed  = (cmd_in == CMD_SEED_WIDE) ? (s_tdata[63:32] ^ s_tdata[31:0])
                                                 : s_tdata[31:0];
    assign seed_load = ((raw_seed[30:0] == '0) || (raw_seed[30:0] == PM_MOD))
                       ? cfg.zero_sentinel : raw_seed[30:0];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        second_next     = second_reg;
        gen_state_next  = gen_state_reg;
        seeded_next     = seeded_reg;
        first_next      = first_reg;
        res_draw_next   = res_draw_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd_in;
                    second_next     = 1'b0;
                    res_draw_next   = '0;
                    res_status_next = 1'b0;
                    case (cmd_in)
                        CMD_SEED_WIDE, CMD_SEED_NARROW:
                        begin
                            gen_state_next = seed_load;
                            seeded_next    = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        CMD_DRAW32, CMD_DRAW64:
                        begin
                            if (seeded_reg)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                gen_state_next = step_result;
                if ((cmd_reg == CMD_DRAW64) && !second_reg)
                begin
                    // hold the high word and go round once more
                    first_next  = step_result;
                    second_next = 1'b1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    if (cmd_reg == CMD_DRAW64)
                    begin
                        res_draw_next = {1'b0, first_reg, 1'b0, step_result};
                    end
                    else
                    begin
                        res_draw_next = {33'd0, step_result};
                    end
                    res_status_next = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_draw_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_SEED_WIDE;
            second_reg    <= 1'b0;
            gen_state_reg <= SENTINEL_RESET;
            seeded_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            second_reg    <= second_next;
            gen_state_reg <= gen_state_next;
            seeded_reg    <= seeded_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        res_draw_reg   <= res_draw_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_state_nondegenerate: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> ((gen_state_reg != '0) && (gen_state_reg != PM_MOD)))
        else $error("generator state reached zero or the modulus");

    a_refused_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("not-seeded status carries a non-zero draw");

    a_seed_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && ((s_tuser == CMD_SEED_WIDE) || (s_tuser == CMD_SEED_NARROW)))
        |=> seeded_reg)
        else $error("seed transaction did not set the seeded flag");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pmsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pmsd_cfg_regs: configuration registers
// Holds the multiplier and the zero sentinel; values that are zero modulo
// 2^31-1 are replaced by the reset value on write.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsd_cfg_regs
    import pmsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_index,
    input  wire pm_word_t cfg_data,
    output cfg_t          cfg
);

    pm_word_t mult_reg;
    pm_word_t mult_next;
    pm_word_t sentinel_reg;
    pm_word_t sentinel_next;
    logic     degenerate;

    assign degenerate = (cfg_data == '0) || (cfg_data == PM_MOD);

    always_comb
    begin
        mult_next     = mult_reg;
        sentinel_next = sentinel_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_MULT:
                begin
                    mult_next = degenerate ? MULT_RESET : cfg_data;
                end
                CFG_IDX_SENTINEL:
                begin
                    sentinel_next = degenerate ? SENTINEL_RESET : cfg_data;
                end
                default:
                begin
                    mult_next = mult_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg     <= MULT_RESET;
            sentinel_reg <= SENTINEL_RESET;
        end
        else
        begin
            mult_reg     <= mult_next;
            sentinel_reg <= sentinel_next;
        end
    end

    assign cfg.multiplier    = mult_reg;
    assign cfg.zero_sentinel = sentinel_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pmsd_step_unit.sv =====
// ----------------------------------------------------------------------------
// pmsd_step_unit: shared multiply and modular fold
// Registers the 31x31 product, then folds it modulo 2^31-1 on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsd_step_unit
    import pmsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     mul_en,
    input  wire pm_word_t operand_a,
    input  wire pm_word_t operand_b,
    output pm_word_t      result
);

    logic [61:0] prod_reg;
    logic [61:0] prod_next;
    logic [31:0] sum_hi_lo;
    pm_word_t    sum_wrap;

    assign prod_next = {31'd0, operand_a} * {31'd0, operand_b};

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // 2^31 == 1 modulo the modulus: add the halves, then the end-around carry
    assign sum_hi_lo = {1'b0, prod_reg[61:31]} + {1'b0, prod_reg[30:0]};
    assign sum_wrap  = sum_hi_lo[30:0] + {30'd0, sum_hi_lo[31]};
    assign result    = (sum_wrap == PM_MOD) ? '0 : sum_wrap;

endmodule

`default_nettype wire
